// ===== rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// shared types and constants for the markdown emphasis tokenizer
// ----------------------------------------------------------------------------
package met_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ITALIC = 2'd1;
    localparam logic [1:0] MODE_BOLD   = 2'd2;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic       is_bold;
        logic       is_italic;
        logic       word_start;
        logic       last_result;
    } t_out_word;

    // all results of one input item, in order from slot 0
    typedef struct packed {
        logic [1:0]                      n;
        t_out_word [MAX_RESULTS-1:0]     res;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/met_front.sv =====
// ----------------------------------------------------------------------------
// met_front
// accepts input words, tracks emphasis state and builds result bundles
// ----------------------------------------------------------------------------
module met_front
    import met_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_bundle  o_bundle
);

    logic [1:0] r_mode, n_mode;
    logic       r_sp, n_sp;
    logic       r_aws, n_aws;
    logic       w_accept;

    function automatic t_out_word mk_text(input logic [7:0] b, input logic [1:0] m,
                                          input logic ws);
        t_out_word w;
        w.kind        = KIND_TEXT;
        w.text_byte   = b;
        w.is_bold     = (m == MODE_BOLD);
        w.is_italic   = (m == MODE_ITALIC);
        w.word_start  = ws;
        w.last_result = 1'b0;
        return w;
    endfunction

    assign o_in_stall = i_q_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        logic [1:0] v_n;
        t_bundle    v_b;
        logic       v_star;
        logic       v_space;
        logic       v_plain;
        v_n     = 2'd0;
        v_b     = '0;
        v_star  = (i_in_data.char_code == STAR_CHAR);
        v_space = (i_in_data.char_code == SPACE_CHAR);
        v_plain = 1'b0;
        n_mode  = (r_mode == MODE_BOLD || r_mode == MODE_ITALIC) ? r_mode : MODE_NORMAL;
        n_sp    = r_sp;
        n_aws   = r_aws;

        if (i_in_data.char_present) begin
            priority if (n_mode == MODE_BOLD) begin
                if (n_sp && v_star) begin
                    n_sp   = 1'b0;
                    n_mode = MODE_NORMAL;
                    n_aws  = 1'b1;
                end else begin
                    if (n_sp) begin
                        // held star goes out as bold text
                        v_b.res[v_n] = mk_text(STAR_CHAR, MODE_BOLD, n_aws);
                        v_n          = v_n + 2'd1;
                        n_aws        = 1'b0;
                        n_sp         = 1'b0;
                    end
                    if (v_star) begin
                        n_sp = 1'b1;
                    end else begin
                        v_plain = 1'b1;
                    end
                end
            end else if (n_mode == MODE_ITALIC) begin
                if (v_star) begin
                    n_mode = MODE_NORMAL;
                    n_aws  = 1'b1;
                end else begin
                    v_plain = 1'b1;
                end
            end else begin
                if (n_sp) begin
                    n_sp  = 1'b0;
                    n_aws = 1'b1;
                    if (v_star) begin
                        n_mode = MODE_BOLD;
                    end else begin
                        n_mode  = MODE_ITALIC;
                        v_plain = 1'b1;
                    end
                end else if (v_star) begin
                    n_sp = 1'b1;
                end else begin
                    v_plain = 1'b1;
                end
            end

            if (v_plain) begin
                if (v_space) begin
                    n_aws = 1'b1;
                end else begin
                    v_b.res[v_n] = mk_text(i_in_data.char_code, n_mode, n_aws);
                    v_n          = v_n + 2'd1;
                    n_aws        = 1'b0;
                end
            end
        end

        if (i_in_data.end_of_line) begin
            if (n_sp && n_mode == MODE_BOLD) begin
                v_b.res[v_n] = mk_text(STAR_CHAR, MODE_BOLD, n_aws);
                v_n          = v_n + 2'd1;
            end
            v_b.res[v_n]      = '0;
            v_b.res[v_n].kind = KIND_EOL;
            v_n               = v_n + 2'd1;
            n_mode            = MODE_NORMAL;
            n_sp              = 1'b0;
            n_aws             = 1'b1;
        end

        if (v_n != 2'd0) begin
            v_b.res[v_n - 2'd1].last_result = 1'b1;
        end
        v_b.n    = v_n;
        o_bundle = v_b;
        o_push   = w_accept && (v_n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_sp   <= 1'b0;
            r_aws  <= 1'b1;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_sp   <= n_sp;
            r_aws  <= n_aws;
        end
    end

endmodule

// ===== rtl/met_queue.sv =====
// ----------------------------------------------------------------------------
// met_queue
// small fifo of result bundles between front and back
// ----------------------------------------------------------------------------
module met_queue
    import met_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_wr_data,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/met_back.sv =====
// ----------------------------------------------------------------------------
// met_back
// unpacks bundles into single result words behind an output register
// ----------------------------------------------------------------------------
module met_back
    import met_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_word  r_data;
    logic       w_load;
    logic       w_last;

    assign w_load = (!r_valid || !i_out_stall) && !i_q_stat.empty;
    assign w_last = (r_idx == i_head.n - 2'd1);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_head.res[r_idx];
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== rtl/markdown_emphasis_tokenizer.sv =====
// ----------------------------------------------------------------------------
// markdown_emphasis_tokenizer: bold/italic tagging of line text, word starts
// an accepted word's results are registered in the fifo, then in the output register
// one input word per cycle while the fifo is not full; an item with k results gives k output words
// sync active-low reset: normal mode, no held star, word start set, fifo empty
// ----------------------------------------------------------------------------
module markdown_emphasis_tokenizer
    import met_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_q_stat w_stat;
    t_bundle w_bundle;
    t_bundle w_head;
    logic    w_push;
    logic    w_pop;

    met_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_stat),
        .o_push     (w_push),
        .o_bundle   (w_bundle)
    );

    met_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_bundle),
        .i_pop     (w_pop),
        .o_head    (w_head),
        .o_stat    (w_stat)
    );

    met_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // fifo never written while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.full |-> !w_push)
        else $error("bundle pushed into full fifo");

    // fifo never popped while empty
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.empty |-> !w_pop)
        else $error("bundle popped from empty fifo");

    // line end marker closes its item and carries no text
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_EOL) |->
        (o_out_data.last_result && o_out_data.text_byte == '0 &&
         !o_out_data.is_bold && !o_out_data.is_italic && !o_out_data.word_start))
        else $error("malformed line end marker");

endmodule
